FILE: design/point_in_polygon_winding_number_core_assert.svh
// Assertion macros for the winding-number point-in-polygon core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef POINT_IN_POLYGON_WINDING_NUMBER_CORE_ASSERT_SVH
`define POINT_IN_POLYGON_WINDING_NUMBER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PIPW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PIPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pipw_pkg.sv
// Shared types and constants for the winding-number point-in-polygon core.
// No dependencies.
`timescale 1ns / 1ps

package pipw_pkg;

  localparam int FIELD_W          = 16;
  localparam int WIND_OUT_W       = 14;
  localparam int DEF_MAX_VERTICES = 4096;
  localparam int DEF_COORD_BITS   = 16;
  localparam int FIFO_DEPTH       = 4;

  // Slots of the point record that travels from the front to the back.
  localparam int PT_PREV  = 0;
  localparam int PT_CUR   = 1;
  localparam int PT_START = 2;
  localparam int PT_POINT = 3;
  localparam int PT_NUM   = 4;
  localparam int AX_X     = 0;
  localparam int AX_Y     = 1;

  // Edge slots in the back end.
  localparam int EDGE_MAIN  = 0;
  localparam int EDGE_CLOSE = 1;

  typedef struct packed {
    logic first;
    logic last;
    logic ovf;
  } pipw_ctl_t;

  typedef struct packed {
    logic s1_valid;
    logic s1_last;
  } pipw_bstat_t;

endpackage

FILE: design/pipw_if.sv
// Vertex and result channel interfaces for the winding-number core.
// Depends on pipw_pkg.
`timescale 1ns / 1ps

interface pipw_in_if import pipw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] vertex_x;
  logic signed [FIELD_W-1:0] vertex_y;
  logic signed [FIELD_W-1:0] query_x;
  logic signed [FIELD_W-1:0] query_y;
  logic                      first_vertex;
  logic                      last_vertex;

  modport source (output valid, vertex_x, vertex_y, query_x, query_y,
                  first_vertex, last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, query_x, query_y,
                first_vertex, last_vertex, output ready);
endinterface

interface pipw_out_if import pipw_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [WIND_OUT_W-1:0] winding;
  logic                         inside_res;
  logic                         overflow;

  modport source (output valid, winding, inside_res, overflow, input ready);
  modport sink (input valid, winding, inside_res, overflow, output ready);
endinterface

FILE: design/pipw_front.sv
// Front end: accepts vertex beats, tracks polygon state, forms edge records.
// Depends on pipw_pkg and pipw_if.
`timescale 1ns / 1ps

module pipw_front import pipw_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int COORD_BITS   = DEF_COORD_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  pipw_in_if.sink                                   in_ch,
  input  logic                                      q_full,
  output logic                                      q_push,
  output logic [PT_NUM-1:0][1:0][COORD_BITS-1:0]    rec_pts,
  output pipw_ctl_t                                 rec_ctl
);

  localparam int VCW = $clog2(MAX_VERTICES + 2);
  localparam logic [VCW-1:0] VC_MAX = VCW'(MAX_VERTICES);
  localparam logic [VCW-1:0] VC_ONE = VCW'(1);

  logic [1:0][COORD_BITS-1:0] start_r, start_nxt;
  logic [1:0][COORD_BITS-1:0] prev_r, prev_nxt;
  logic [1:0][COORD_BITS-1:0] point_r, point_nxt;
  logic [1:0][COORD_BITS-1:0] cur;
  logic [1:0][COORD_BITS-1:0] query;
  logic [VCW-1:0]             vcnt_r, vcnt_nxt;
  logic [31:0]                vx_ext, vy_ext, qx_ext, qy_ext;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // The low COORD_BITS of each field form the coordinate.
  assign vx_ext = 32'(unsigned'(in_ch.vertex_x));
  assign vy_ext = 32'(unsigned'(in_ch.vertex_y));
  assign qx_ext = 32'(unsigned'(in_ch.query_x));
  assign qy_ext = 32'(unsigned'(in_ch.query_y));
  assign cur[AX_X]   = vx_ext[COORD_BITS-1:0];
  assign cur[AX_Y]   = vy_ext[COORD_BITS-1:0];
  assign query[AX_X] = qx_ext[COORD_BITS-1:0];
  assign query[AX_Y] = qy_ext[COORD_BITS-1:0];

  always_comb begin
    prev_nxt = cur;
    if (in_ch.first_vertex) begin
      start_nxt = cur;
      point_nxt = query;
      vcnt_nxt  = VC_ONE;
    end else begin
      start_nxt = start_r;
      point_nxt = point_r;
      vcnt_nxt  = (vcnt_r <= VC_MAX) ? vcnt_r + VC_ONE : vcnt_r;
    end
  end

  always_comb begin
    rec_pts[PT_PREV]  = prev_r;
    rec_pts[PT_CUR]   = cur;
    rec_pts[PT_START] = start_nxt;
    rec_pts[PT_POINT] = point_nxt;
    rec_ctl.first     = in_ch.first_vertex;
    rec_ctl.last      = in_ch.last_vertex;
    rec_ctl.ovf       = vcnt_nxt > VC_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      prev_r  <= '0;
      point_r <= '0;
      vcnt_r  <= '0;
    end else if (q_push) begin
      start_r <= start_nxt;
      prev_r  <= prev_nxt;
      point_r <= point_nxt;
      vcnt_r  <= vcnt_nxt;
    end
  end

endmodule

FILE: design/pipw_fifo.sv
// Small synchronous queue between the front and back ends.
// Depends on pipw_pkg.
`timescale 1ns / 1ps

module pipw_fifo import pipw_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam logic [AW:0] CNT_FULL = (AW + 1)'(FIFO_DEPTH);

  logic [WIDTH-1:0] mem [FIFO_DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = cnt_r == CNT_FULL;
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: design/pipw_back.sv
// Back end: edge cross products, crossing tests, winding accumulator, result register.
// Depends on pipw_pkg and pipw_if.
`timescale 1ns / 1ps

module pipw_back import pipw_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int COORD_BITS   = DEF_COORD_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_empty,
  input  logic [PT_NUM-1:0][1:0][COORD_BITS-1:0] q_pts,
  input  pipw_ctl_t                              q_ctl,
  output logic                                   q_pop,
  output pipw_bstat_t                            bstat,
  pipw_out_if.source                             out_ch
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int WW = $clog2(MAX_VERTICES + 1) + 1;
  localparam logic signed [WW-1:0] W_MAX = WW'(MAX_VERTICES);
  localparam logic signed [WW-1:0] W_MIN = -W_MAX;
  localparam logic signed [WW-1:0] W_ONE = WW'(1);

  function automatic logic signed [WW-1:0] wstep(input logic signed [WW-1:0] w,
                                                 input logic inc, input logic dec);
    logic signed [WW-1:0] r;
    r = w;
    if (inc && w != W_MAX) begin
      r = w + W_ONE;
    end else if (dec && w != W_MIN) begin
      r = w - W_ONE;
    end
    return r;
  endfunction

  // Stage 1: products and crossing direction for both edges.
  logic signed [1:0][PW-1:0] lhs, rhs;
  logic [1:0]                up, dn;
  logic signed [1:0][PW-1:0] s1_lhs_r, s1_rhs_r;
  logic [1:0]                s1_up_r, s1_dn_r;
  pipw_ctl_t                 s1_ctl_r;
  logic                      s1_valid_r, s1_valid_nxt;
  logic                      s1_go, s1_load, out_free;

  always_comb begin
    logic signed [DW-1:0] x0, y0, x1, y1, px, py;
    for (int e = 0; e < 2; e++) begin
      if (e == EDGE_MAIN) begin
        x0 = DW'($signed(q_pts[PT_PREV][AX_X]));
        y0 = DW'($signed(q_pts[PT_PREV][AX_Y]));
        x1 = DW'($signed(q_pts[PT_CUR][AX_X]));
        y1 = DW'($signed(q_pts[PT_CUR][AX_Y]));
      end else begin
        x0 = DW'($signed(q_pts[PT_CUR][AX_X]));
        y0 = DW'($signed(q_pts[PT_CUR][AX_Y]));
        x1 = DW'($signed(q_pts[PT_START][AX_X]));
        y1 = DW'($signed(q_pts[PT_START][AX_Y]));
      end
      px = DW'($signed(q_pts[PT_POINT][AX_X]));
      py = DW'($signed(q_pts[PT_POINT][AX_Y]));
      lhs[e] = PW'(x1 - x0) * PW'(py - y0);
      rhs[e] = PW'(px - x0) * PW'(y1 - y0);
      up[e]  = (y0 <= py) && (y1 > py);
      dn[e]  = (y0 > py) && (y1 <= py);
    end
  end

  // Stage 2: sign of the cross product, saturating accumulate, result.
  logic                 inc_m, dec_m, inc_c, dec_c;
  logic signed [WW-1:0] wind_r, wind_nxt, w0, w1;
  logic signed [31:0]   wind_ext;

  assign out_free = !out_ch.valid || out_ch.ready;
  assign s1_go    = s1_valid_r && (!s1_ctl_r.last || out_free);
  assign s1_load  = !s1_valid_r || s1_go;
  assign q_pop    = s1_load && !q_empty;

  assign bstat.s1_valid = s1_valid_r;
  assign bstat.s1_last  = s1_ctl_r.last;

  // Elements of a packed array are unsigned, so the products are compared
  // as signed values explicitly.
  always_comb begin
    inc_m = !s1_ctl_r.first && s1_up_r[EDGE_MAIN] &&
            ($signed(s1_lhs_r[EDGE_MAIN]) > $signed(s1_rhs_r[EDGE_MAIN]));
    dec_m = !s1_ctl_r.first && s1_dn_r[EDGE_MAIN] &&
            ($signed(s1_lhs_r[EDGE_MAIN]) < $signed(s1_rhs_r[EDGE_MAIN]));
    inc_c = s1_ctl_r.last && s1_up_r[EDGE_CLOSE] &&
            ($signed(s1_lhs_r[EDGE_CLOSE]) > $signed(s1_rhs_r[EDGE_CLOSE]));
    dec_c = s1_ctl_r.last && s1_dn_r[EDGE_CLOSE] &&
            ($signed(s1_lhs_r[EDGE_CLOSE]) < $signed(s1_rhs_r[EDGE_CLOSE]));
    w0       = s1_ctl_r.first ? '0 : wind_r;
    w1       = wstep(w0, inc_m, dec_m);
    wind_nxt = wstep(w1, inc_c, dec_c);
    wind_ext = 32'(wind_nxt);
    s1_valid_nxt = q_pop ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_lhs_r <= lhs;
      s1_rhs_r <= rhs;
      s1_up_r  <= up;
      s1_dn_r  <= dn;
      s1_ctl_r <= q_ctl;
    end
    if (s1_go && s1_ctl_r.last) begin
      out_ch.winding    <= wind_ext[WIND_OUT_W-1:0];
      out_ch.inside_res <= wind_nxt != '0;
      out_ch.overflow   <= s1_ctl_r.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      wind_r       <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_go) begin
        wind_r <= wind_nxt;
      end
      if (s1_go && s1_ctl_r.last) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/point_in_polygon_winding_number_core.sv
// Winding-number point-in-polygon core: one vertex beat per cycle while the queue has room.
// A result beat is registered after the beat of the last vertex is accepted, passing the queue
// write, then the product stage, then the result register; the multiplier stage and the winding
// accumulator each take one vertex a cycle while the result register is not held downstream.
// Reset (rst_n low, synchronous) clears the polygon state, the queue and the result valid flag.
// Depends on pipw_pkg, pipw_if, pipw_front, pipw_fifo, pipw_back and the assertion header.
`timescale 1ns / 1ps
`include "point_in_polygon_winding_number_core_assert.svh"

module point_in_polygon_winding_number_core import pipw_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int COORD_BITS   = DEF_COORD_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  pipw_in_if.sink     in_ch,
  pipw_out_if.source  out_ch
);

  // One queue entry: the control flags above the four points.
  localparam int PTS_W = PT_NUM * 2 * COORD_BITS;
  localparam int REC_W = PTS_W + $bits(pipw_ctl_t);

  logic [PT_NUM-1:0][1:0][COORD_BITS-1:0] rec_pts, q_pts;
  pipw_ctl_t                              rec_ctl, q_ctl;
  logic [REC_W-1:0]                       q_din, q_dout;
  logic                                   q_push, q_pop, q_full, q_empty;
  pipw_bstat_t                            bstat;

  // The front end keeps the first vertex, the previous vertex, the query
  // point and the vertex count. Each accepted beat becomes a record holding
  // both edges it may need: previous to current, and current to first.
  pipw_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .rec_pts (rec_pts),
    .rec_ctl (rec_ctl)
  );

  assign q_din = {rec_ctl, rec_pts};

  // The queue lets the front keep taking vertices while the result
  // register waits on the downstream side.
  pipw_fifo #(
    .WIDTH (REC_W)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_pts = q_dout[PTS_W-1:0];
  assign q_ctl = q_dout[REC_W-1:PTS_W];

  // The back end forms the two cross products of each edge, then compares
  // them to get the sign of IsLeft, and updates the clamped winding count.
  // Only a record marked last moves a result into the output register.
  pipw_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_pts   (q_pts),
    .q_ctl   (q_ctl),
    .q_pop   (q_pop),
    .bstat   (bstat),
    .out_ch  (out_ch)
  );

  // A full queue must hold off the vertex channel.
  `PIPW_ASSERT_NOW(a_full_blocks_input, q_full, !in_ch.ready, "vertex taken while queue full")

  // A free product stage always pulls a waiting record.
  `PIPW_ASSERT_NEXT(a_stage_fills, !q_empty && !bstat.s1_valid, bstat.s1_valid,
                    "product stage idle while queue holds a record")

  // A new result only appears behind a record marked last.
  `PIPW_ASSERT_NOW(a_result_from_last, $rose(out_ch.valid),
                   $past(bstat.s1_valid && bstat.s1_last), "result without a last vertex")

endmodule
